// ----- rtl/core/toroidal_tile_window_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Tile window table assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_TILE_WINDOW_TABLE_UNIT_DEFINES_SVH
`define TOROIDAL_TILE_WINDOW_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ttw_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile window table package
// Field widths, result and action codes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
package ttw_pkg;

   localparam int COORD_W    = 24;
   localparam int GEN_W      = 16;
   localparam int SLOT_W     = 6;
   localparam int KIND_W     = 2;
   localparam int DIST_W     = 2;
   localparam int CHG_W      = 6;
   localparam int WRAP_W     = 3;  // wrapped coordinate, side up to 8
   localparam int DEF_RADIUS = 3;
   localparam int DEF_SIDE   = 7;

   localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   localparam logic ACT_RECENTER = 1'b0;
   localparam logic ACT_LOOKUP   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_X,
      ST_MOD_Z,
      ST_DISPATCH,
      ST_LOOK_OUT,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SWEEP_RD,
      ST_SWEEP_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] home_x;
      logic signed [COORD_W-1:0] home_z;
      logic [GEN_W-1:0]          gen;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic                      last;
      logic signed [COORD_W-1:0] old_x;
      logic signed [COORD_W-1:0] old_z;
      logic [SLOT_W-1:0]         slot;
      logic                      in_range;
      logic [DIST_W-1:0]         distance;
      logic                      hit;
      logic [GEN_W-1:0]          generation;
      logic [CHG_W-1:0]          changed;
   } rsp_word_type;

   // Exact magnitude of a - b, one bit wider than the coordinates.
   function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[COORD_W] ? (~d + 1'b1) : d;
   endfunction

endpackage

// ----- rtl/core/ttw_if.sv -----
// ----------------------------------------------------------------------------
// Tile window table channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface ttw_req_if;
   import ttw_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, action, coord_x, coord_z, input ready);
   modport sink   (input valid, action, coord_x, coord_z, output ready);
endinterface

interface ttw_rsp_if;
   import ttw_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic                      last;
   logic signed [COORD_W-1:0] old_x;
   logic signed [COORD_W-1:0] old_z;
   logic [SLOT_W-1:0]         slot;
   logic                      in_range;
   logic [DIST_W-1:0]         distance;
   logic                      hit;
   logic [GEN_W-1:0]          generation;
   logic [CHG_W-1:0]          changed;

   modport source (output valid, kind, last, old_x, old_z, slot, in_range, distance, hit,
                   generation, changed, input ready);
   modport sink   (input valid, kind, last, old_x, old_z, slot, in_range, distance, hit,
                   generation, changed, output ready);
endinterface

// ----- rtl/core/toroidal_tile_window_table_unit.sv -----
// ----------------------------------------------------------------------------
// Toroidal tile window table
// Slot table of a square tile window addressed by coordinates wrapped
// modulo SIDE; recenters the window and answers tile lookups.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one word per operation: action 0 recenters the window on
//   (coord_x, coord_z), action 1 looks that tile up. rsp_ch returns words;
//   last marks the final word of an operation.
//   A lookup gives one answer word. A recenter gives eviction words (walk
//   order, then slot order of the sweep) followed by one done word.
//   Both coordinates are first wrapped by one shared reciprocal-multiply
//   modulo unit, each coordinate in a quotient step, then a remainder step.
//   A lookup then reads its slot and loads its answer word; the unit returns
//   to idle and takes the next word once the answer is loaded.
//   A recenter walks the (2*RADIUS+1)^2 window tiles through the slot
//   memory, reading each tile and then checking and writing it; a tile off
//   the coordinate range is skipped unread. The sweep, when needed, steps
//   past each empty slot and reads, then checks each occupied slot. A
//   recenter on the current centre skips walk and sweep and gives only its
//   done word.
//   req_ch.ready is high only between operations. A stalled rsp_ch holds the
//   output register and pauses the sequencer at its next word.
//   Reset (synchronous) empties the table: all slots vacant, generations
//   read as zero, window not yet centred. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "toroidal_tile_window_table_unit_defines.svh"

module toroidal_tile_window_table_unit #(
   parameter int RADIUS = ttw_pkg::DEF_RADIUS,
   parameter int SIDE   = ttw_pkg::DEF_SIDE
) (
   input  logic      clock,
   input  logic      reset,
   ttw_req_if.sink   req_ch,
   ttw_rsp_if.source rsp_ch
);
   import ttw_pkg::*;

   localparam int SLOTS   = SIDE * SIDE;
   localparam int SPAN    = 2 * RADIUS + 1;
   localparam int TILES   = SPAN * SPAN;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SPAN_W  = $clog2(SPAN);
   // Coordinates enter the modulo unit as offset binary (x + 2^23).
   localparam int OFF_REM = (1 << (COORD_W - 1)) % SIDE;
   // Rounded-up reciprocal of SIDE; exact quotient for every 24-bit operand.
   localparam int MOD_SHIFT = COORD_W + 3;
   localparam int PROD_W    = COORD_W + MOD_SHIFT;
   localparam logic [MOD_SHIFT-1:0] MOD_RECIP =
      MOD_SHIFT'(((1 << MOD_SHIFT) + SIDE - 1) / SIDE);

   // Sequencer
   state_type state_ff, state_in;

   // Operation registers
   logic                      act_ff;
   logic signed [COORD_W-1:0] px_ff, pz_ff;
   logic signed [COORD_W-1:0] cx_ff, cz_ff;
   logic                      centred_ff;

   // Shared modulo unit
   logic [COORD_W-1:0] mod_op_ff;
   logic [COORD_W-1:0] mod_q_ff;
   logic               mod_step_ff;
   logic [PROD_W-1:0]  mod_prod;
   logic [COORD_W-1:0] mod_quo, mod_rem;
   logic [WRAP_W:0]    mod_t, mod_fix;
   logic [WRAP_W-1:0]  mod_wrap;
   logic               mod_run, mod_done;

   // Walk and sweep position
   logic [WRAP_W-1:0] wpx_ff, wpz_ff;
   logic [WRAP_W-1:0] wx0_ff, wx_ff, wz_ff;
   logic [WRAP_W-1:0] start_x, start_z;
   logic [SPAN_W-1:0] ix_ff, iz_ff;
   logic [IDX_W-1:0]  sidx_ff;
   logic              sweep_ff;
   logic [CHG_W-1:0]  changed_ff;

   // Lookup
   logic              look_inr_ff;
   logic [DIST_W-1:0] look_dist_ff;
   logic [COORD_W:0]  dx, dz, dmax;
   logic              same_centre, jump;

   // Slot state
   logic [SLOTS-1:0] occupied_ff;
   logic [SLOTS-1:0] written_ff;
   entry_type        slot_mem [SLOTS];
   entry_type        rd_ff;

   // Derived conditions
   logic signed [COORD_W:0] cur_x, cur_z;
   logic                    tile_ok;
   logic [IDX_W-1:0]        walk_idx, look_idx;
   logic                    walk_occ, walk_match, walk_end;
   logic                    sweep_out, sweep_end;
   logic [GEN_W-1:0]        walk_gen;
   logic                    out_free;
   state_type               walk_next;

   // Control
   logic             accept;
   logic             mem_rd, mem_wr;
   logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
   entry_type        mem_wr_data;
   logic             emit;
   rsp_word_type     emit_word;
   logic             walk_adv, walk_write, sweep_adv, sweep_write;

   // Output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;

   function automatic logic [IDX_W-1:0] slot_at(input logic [WRAP_W-1:0] wx,
                                                input logic [WRAP_W-1:0] wz);
      return IDX_W'(wz) * IDX_W'(SIDE) + IDX_W'(wx);
   endfunction

   function automatic logic [WRAP_W-1:0] wrap_inc(input logic [WRAP_W-1:0] w);
      return (w == WRAP_W'(SIDE - 1)) ? '0 : w + 1'b1;
   endfunction

   // Step back RADIUS tiles around the torus.
   function automatic logic [WRAP_W-1:0] wrap_start(input logic [WRAP_W-1:0] w);
      logic [WRAP_W:0] s;
      s = {1'b0, w} + (WRAP_W + 1)'(SIDE - RADIUS);
      if (s >= (WRAP_W + 1)'(SIDE)) begin
         s = s - (WRAP_W + 1)'(SIDE);
      end
      return s[WRAP_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] offset_bin(input logic signed [COORD_W-1:0] c);
      return {~c[COORD_W-1], c[COORD_W-2:0]};
   endfunction

   // ------------------------------------------------------------------------
   // Conditions
   // ------------------------------------------------------------------------
   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // First step: quotient by reciprocal multiplication. Second step: multiply
   // back and subtract to get the remainder.
   always_comb begin
      mod_prod = PROD_W'(mod_op_ff) * PROD_W'(MOD_RECIP);
      mod_quo  = mod_prod[PROD_W-1:MOD_SHIFT];
      mod_rem  = mod_op_ff - mod_q_ff * COORD_W'(SIDE);
      mod_t    = mod_rem[WRAP_W:0];
      // Remove the offset-binary bias.
      mod_fix = (mod_t >= (WRAP_W + 1)'(OFF_REM)) ? mod_t - (WRAP_W + 1)'(OFF_REM)
                                                  : mod_t + (WRAP_W + 1)'(SIDE - OFF_REM);
      mod_wrap = mod_fix[WRAP_W-1:0];
   end

   assign mod_run  = (state_ff == ST_MOD_X) || (state_ff == ST_MOD_Z);
   assign mod_done = mod_step_ff;

   assign dx   = abs_diff(px_ff, cx_ff);
   assign dz   = abs_diff(pz_ff, cz_ff);
   assign dmax = (dx > dz) ? dx : dz;
   assign same_centre = centred_ff && (px_ff == cx_ff) && (pz_ff == cz_ff);
   assign jump = !centred_ff || (dx > (COORD_W + 1)'(1)) || (dz > (COORD_W + 1)'(1));

   assign start_x = wrap_start(wpx_ff);
   assign start_z = wrap_start(wpz_ff);

   // Current window tile; drop tiles outside the signed coordinate range.
   assign cur_x   = {px_ff[COORD_W-1], px_ff} - (COORD_W + 1)'(RADIUS)
                    + (COORD_W + 1)'(ix_ff);
   assign cur_z   = {pz_ff[COORD_W-1], pz_ff} - (COORD_W + 1)'(RADIUS)
                    + (COORD_W + 1)'(iz_ff);
   assign tile_ok = (cur_x[COORD_W] == cur_x[COORD_W-1]) &&
                    (cur_z[COORD_W] == cur_z[COORD_W-1]);

   assign walk_idx   = slot_at(wx_ff, wz_ff);
   assign look_idx   = slot_at(wpx_ff, wpz_ff);
   assign walk_occ   = occupied_ff[walk_idx];
   assign walk_match = walk_occ && (rd_ff.home_x == cur_x[COORD_W-1:0]) &&
                       (rd_ff.home_z == cur_z[COORD_W-1:0]);
   assign walk_gen   = written_ff[walk_idx] ? rd_ff.gen : '0;
   assign walk_end   = (ix_ff == SPAN_W'(SPAN - 1)) && (iz_ff == SPAN_W'(SPAN - 1));
   assign walk_next  = walk_end ? (sweep_ff ? ST_SWEEP_RD : ST_DONE) : ST_WALK_RD;

   assign sweep_out = (abs_diff(rd_ff.home_x, px_ff) > (COORD_W + 1)'(RADIUS)) ||
                      (abs_diff(rd_ff.home_z, pz_ff) > (COORD_W + 1)'(RADIUS));
   assign sweep_end = (sidx_ff == IDX_W'(SLOTS - 1));

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MOD_X;
         end
         ST_MOD_X: begin
            if (mod_done) state_in = ST_MOD_Z;
         end
         ST_MOD_Z: begin
            if (mod_done) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (act_ff == ACT_LOOKUP) state_in = ST_LOOK_OUT;
            else if (same_centre)     state_in = ST_DONE;
            else                      state_in = ST_WALK_RD;
         end
         ST_LOOK_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_WALK_RD: begin
            state_in = tile_ok ? ST_WALK_CHK : walk_next;
         end
         ST_WALK_CHK: begin
            if (walk_match || !walk_occ || out_free) state_in = walk_next;
         end
         ST_SWEEP_RD: begin
            if (occupied_ff[sidx_ff]) state_in = ST_SWEEP_CHK;
            else                      state_in = sweep_end ? ST_DONE : ST_SWEEP_RD;
         end
         ST_SWEEP_CHK: begin
            if (!sweep_out || out_free) state_in = sweep_end ? ST_DONE : ST_SWEEP_RD;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Control outputs
   // ------------------------------------------------------------------------
   always_comb begin
      mem_rd      = 1'b0;
      mem_rd_addr = walk_idx;
      mem_wr      = 1'b0;
      mem_wr_addr = walk_idx;
      mem_wr_data = '{home_x: cur_x[COORD_W-1:0], home_z: cur_z[COORD_W-1:0],
                      gen: walk_gen + 1'b1};
      emit        = 1'b0;
      emit_word   = '0;
      walk_adv    = 1'b0;
      walk_write  = 1'b0;
      sweep_adv   = 1'b0;
      sweep_write = 1'b0;
      case (state_ff)
         ST_DISPATCH: begin
            if (act_ff == ACT_LOOKUP) begin
               mem_rd      = 1'b1;
               mem_rd_addr = look_idx;
            end
         end
         ST_LOOK_OUT: begin
            emit           = out_free;
            emit_word.kind = KIND_LOOKUP;
            emit_word.last = 1'b1;
            if (look_inr_ff) begin
               emit_word.slot       = SLOT_W'(look_idx);
               emit_word.in_range   = 1'b1;
               emit_word.distance   = look_dist_ff;
               emit_word.hit        = occupied_ff[look_idx] &&
                                      (rd_ff.home_x == px_ff) && (rd_ff.home_z == pz_ff);
               emit_word.generation = written_ff[look_idx] ? rd_ff.gen : '0;
            end
         end
         ST_WALK_RD: begin
            mem_rd   = tile_ok;
            walk_adv = !tile_ok;
         end
         ST_WALK_CHK: begin
            walk_write = !walk_match && (!walk_occ || out_free);
            walk_adv   = walk_match || !walk_occ || out_free;
            mem_wr     = walk_write;
            // Displaced occupant gets an eviction word.
            emit                 = !walk_match && walk_occ && out_free;
            emit_word.kind       = KIND_EVICT;
            emit_word.old_x      = rd_ff.home_x;
            emit_word.old_z      = rd_ff.home_z;
            emit_word.slot       = SLOT_W'(walk_idx);
            emit_word.generation = rd_ff.gen;
         end
         ST_SWEEP_RD: begin
            mem_rd      = occupied_ff[sidx_ff];
            mem_rd_addr = sidx_ff;
            sweep_adv   = !occupied_ff[sidx_ff];
         end
         ST_SWEEP_CHK: begin
            sweep_write = sweep_out && out_free;
            sweep_adv   = !sweep_out || out_free;
            mem_wr      = sweep_write;
            mem_wr_addr = sidx_ff;
            mem_wr_data = '{home_x: rd_ff.home_x, home_z: rd_ff.home_z,
                            gen: rd_ff.gen + 1'b1};
            emit                 = sweep_write;
            emit_word.kind       = KIND_EVICT;
            emit_word.old_x      = rd_ff.home_x;
            emit_word.old_z      = rd_ff.home_z;
            emit_word.slot       = SLOT_W'(sidx_ff);
            emit_word.generation = rd_ff.gen;
         end
         ST_DONE: begin
            emit              = out_free;
            emit_word.kind    = KIND_DONE;
            emit_word.last    = 1'b1;
            emit_word.changed = changed_ff;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         occupied_ff  <= '0;
         written_ff   <= '0;
         centred_ff   <= 1'b0;
         cx_ff        <= '0;
         cz_ff        <= '0;
         changed_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (walk_write) begin
            occupied_ff[walk_idx] <= 1'b1;
            written_ff[walk_idx]  <= 1'b1;
         end
         if (sweep_write) begin
            occupied_ff[sidx_ff] <= 1'b0;
         end
         if (state_ff == ST_DISPATCH) begin
            changed_ff <= '0;
         end else if (walk_write) begin
            changed_ff <= changed_ff + 1'b1;
         end
         // Commit the new centre with the done word.
         if ((state_ff == ST_DONE) && out_free) begin
            cx_ff      <= px_ff;
            cz_ff      <= pz_ff;
            centred_ff <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_word;
      end

      if (accept) begin
         act_ff      <= req_ch.action;
         px_ff       <= req_ch.coord_x;
         pz_ff       <= req_ch.coord_z;
         mod_op_ff   <= offset_bin(req_ch.coord_x);
         mod_step_ff <= 1'b0;
      end else if (mod_run) begin
         if (mod_done) begin
            if (state_ff == ST_MOD_X) begin
               wpx_ff <= mod_wrap;
            end else begin
               wpz_ff <= mod_wrap;
            end
            mod_op_ff   <= offset_bin(pz_ff);
            mod_step_ff <= 1'b0;
         end else begin
            mod_q_ff    <= mod_quo;
            mod_step_ff <= 1'b1;
         end
      end

      if (state_ff == ST_DISPATCH) begin
         look_inr_ff  <= centred_ff && (dmax <= (COORD_W + 1)'(RADIUS));
         look_dist_ff <= dmax[DIST_W-1:0];
         sweep_ff     <= jump;
         wx0_ff       <= start_x;
         wx_ff        <= start_x;
         wz_ff        <= start_z;
         ix_ff        <= '0;
         iz_ff        <= '0;
         sidx_ff      <= '0;
      end

      if (walk_adv) begin
         if (ix_ff == SPAN_W'(SPAN - 1)) begin
            ix_ff <= '0;
            wx_ff <= wx0_ff;
            iz_ff <= iz_ff + 1'b1;
            wz_ff <= wrap_inc(wz_ff);
         end else begin
            ix_ff <= ix_ff + 1'b1;
            wx_ff <= wrap_inc(wx_ff);
         end
      end

      if (sweep_adv) begin
         sidx_ff <= sidx_ff + 1'b1;
      end
   end

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd) begin
         rd_ff <= slot_mem[mem_rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------------
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_ff.kind;
   assign rsp_ch.last       = rsp_ff.last;
   assign rsp_ch.old_x      = rsp_ff.old_x;
   assign rsp_ch.old_z      = rsp_ff.old_z;
   assign rsp_ch.slot       = rsp_ff.slot;
   assign rsp_ch.in_range   = rsp_ff.in_range;
   assign rsp_ch.distance   = rsp_ff.distance;
   assign rsp_ch.hit        = rsp_ff.hit;
   assign rsp_ch.generation = rsp_ff.generation;
   assign rsp_ch.changed    = rsp_ff.changed;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `TTW_ASSERT_NOW(a_occ_written, 1'b1, (occupied_ff & ~written_ff) == '0, "occupied slot never written")
   `TTW_ASSERT_NOW(a_changed_bound, 1'b1, changed_ff <= CHG_W'(TILES), "rehome count past window size")
   `TTW_ASSERT_NOW(a_evict_not_last, rsp_valid_ff && (rsp_ff.kind == KIND_EVICT), !rsp_ff.last, "eviction word marked last")
   `TTW_ASSERT_NEXT(a_busy_after_accept, accept, state_ff != ST_IDLE, "sequencer idle after accept")

endmodule

// ----- verif/toroidal_tile_window_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal tile window table testbench
// Sends recenter and lookup words, first from a directed table and then from
// a random walk around the window centre. A behavioral copy of the slot table
// predicts all words no directed row gives. Both channels stall at random.
// ----------------------------------------------------------------------------
module toroidal_tile_window_table_unit_tb;
   import ttw_pkg::*;

   localparam int     WIN_RADIUS   = DEF_RADIUS;
   localparam int     WIN_SIDE     = DEF_SIDE;
   localparam int     WIN_SLOTS    = WIN_SIDE * WIN_SIDE;
   localparam longint COORD_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN    = -(longint'(1) <<< (COORD_W - 1));
   localparam int     CLK_PERIOD   = 10;
   localparam int     RESET_CYCLES = 6;
   localparam int     MAX_IDLE     = 17;
   localparam int     NUM_ROWS     = 25;
   localparam int     NUM_RANDOM   = 480;
   // Random-part item indexes where the pressure phases start.
   localparam int     HOLD_AT      = 150;
   localparam int     HOLD_CYCLES  = 600;
   localparam int     BRISK_FIRST  = 200;
   localparam int     BRISK_LAST   = 259;
   localparam int     SETTLE_AT    = 320;
   localparam int     DRAIN_CYCLES = 400;
   localparam int     LIMIT_CYCLES = 5_000_000;
   localparam int     REPORT_LIMIT = 10;

   // One directed stimulus row. When typed is set, word holds the single
   // response word expected for the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic                      typed;
      rsp_word_type              word;
   } tile_row_type;

   logic clock = 1'b0;
   logic reset;

   ttw_req_if req_ch();
   ttw_rsp_if rsp_ch();

   toroidal_tile_window_table_unit #(
      .RADIUS (WIN_RADIUS),
      .SIDE   (WIN_SIDE)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Slot table copy: homes, generations, occupancy and window centre.
   // -------------------------------------------------------------------------
   logic signed [COORD_W-1:0] tile_home_x [WIN_SLOTS];
   logic signed [COORD_W-1:0] tile_home_z [WIN_SLOTS];
   logic [GEN_W-1:0]          tile_gen    [WIN_SLOTS];
   logic                      tile_held   [WIN_SLOTS];
   logic signed [COORD_W-1:0] win_x;
   logic signed [COORD_W-1:0] win_z;
   logic                      win_set;

   rsp_word_type step_words[$];     // words caused by the item just accepted
   rsp_word_type pending_words[$];  // words still owed by the block

   int unsigned failures        = 0;
   int unsigned words_checked   = 0;
   int unsigned evictions_seen  = 0;
   int unsigned recenters_sent  = 0;
   int unsigned lookups_sent    = 0;
   int unsigned cycle_count     = 0;
   bit          brisk           = 1'b0;  // no idling on either side
   bit          hold_rsp        = 1'b0;  // ask the sink for one long hold-off

   function automatic longint coord_gap(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Nonnegative remainder, so negative tiles land in the right slot.
   function automatic int unsigned slot_of(input longint x, input longint z);
      longint mx;
      longint mz;
      mx = x % WIN_SIDE;
      mz = z % WIN_SIDE;
      if (mx < 0) mx += WIN_SIDE;
      if (mz < 0) mz += WIN_SIDE;
      return int'(mx + mz * WIN_SIDE);
   endfunction

   function automatic rsp_word_type answer_word(input logic [SLOT_W-1:0] s,
                                                input logic inr,
                                                input logic [DIST_W-1:0] span,
                                                input logic hit,
                                                input logic [GEN_W-1:0] gen);
      rsp_word_type w;
      w            = '0;
      w.kind       = KIND_LOOKUP;
      w.last       = 1'b1;
      w.slot       = s;
      w.in_range   = inr;
      w.distance   = span;
      w.hit        = hit;
      w.generation = gen;
      return w;
   endfunction

   function automatic rsp_word_type done_word(input logic [CHG_W-1:0] chg);
      rsp_word_type w;
      w         = '0;
      w.kind    = KIND_DONE;
      w.last    = 1'b1;
      w.changed = chg;
      return w;
   endfunction

   function automatic rsp_word_type evict_word(input int unsigned s);
      rsp_word_type w;
      w            = '0;
      w.kind       = KIND_EVICT;
      w.old_x      = tile_home_x[s];
      w.old_z      = tile_home_z[s];
      w.slot       = SLOT_W'(s);
      w.generation = tile_gen[s];
      return w;
   endfunction

   // Apply one request word to the table copy and collect the words it owes
   // in step_words.
   function automatic void window_step(input logic act,
                                       input logic signed [COORD_W-1:0] cx,
                                       input logic signed [COORD_W-1:0] cz);
      longint      px;
      longint      pz;
      longint      x;
      longint      z;
      longint      d;
      int unsigned s;
      int unsigned moved;
      logic        hit;
      px = longint'(cx);
      pz = longint'(cz);
      step_words.delete();

      if (act == ACT_LOOKUP) begin
         d = coord_gap(px, win_x);
         if (coord_gap(pz, win_z) > d) d = coord_gap(pz, win_z);
         if (!win_set || d > WIN_RADIUS) begin
            step_words.push_back(answer_word('0, 1'b0, '0, 1'b0, '0));
         end else begin
            s   = slot_of(px, pz);
            hit = tile_held[s] && longint'(tile_home_x[s]) == px &&
                  longint'(tile_home_z[s]) == pz;
            step_words.push_back(answer_word(SLOT_W'(s), 1'b1, DIST_W'(d), hit,
                                             tile_gen[s]));
         end
         return;
      end

      // Recenter on the current centre: nothing moves.
      if (win_set && px == win_x && pz == win_z) begin
         step_words.push_back(done_word('0));
         return;
      end

      // Walk the new window z-major; tiles past the coordinate range are skipped.
      moved = 0;
      for (z = pz - WIN_RADIUS; z <= pz + WIN_RADIUS; z++) begin
         if (z < COORD_MIN || z > COORD_MAX) continue;
         for (x = px - WIN_RADIUS; x <= px + WIN_RADIUS; x++) begin
            if (x < COORD_MIN || x > COORD_MAX) continue;
            s = slot_of(x, z);
            if (tile_held[s] && longint'(tile_home_x[s]) == x &&
                longint'(tile_home_z[s]) == z) continue;
            if (tile_held[s]) step_words.push_back(evict_word(s));
            tile_home_x[s] = COORD_W'(x);
            tile_home_z[s] = COORD_W'(z);
            tile_gen[s]    = tile_gen[s] + 1'b1;
            tile_held[s]   = 1'b1;
            moved++;
         end
      end

      // Sweep only on the first recenter or after a jump of more than one tile.
      if (!win_set || coord_gap(px, win_x) > 1 || coord_gap(pz, win_z) > 1) begin
         for (int i = 0; i < WIN_SLOTS; i++) begin
            if (!tile_held[i]) continue;
            if (coord_gap(tile_home_x[i], px) > WIN_RADIUS ||
                coord_gap(tile_home_z[i], pz) > WIN_RADIUS) begin
               step_words.push_back(evict_word(i));
               tile_held[i] = 1'b0;
               tile_gen[i]  = tile_gen[i] + 1'b1;
            end
         end
      end

      win_x   = cx;
      win_z   = cz;
      win_set = 1'b1;
      step_words.push_back(done_word(CHG_W'(moved)));
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf({"kind=%0d last=%0d old=(%0d,%0d) slot=%0d in_range=%0d ",
                        "dist=%0d hit=%0d gen=%0d changed=%0d"},
                       w.kind, w.last, w.old_x, w.old_z, w.slot, w.in_range,
                       w.distance, w.hit, w.generation, w.changed);
   endfunction

   // Count every failure; print details for the first few only.
   function automatic void note_failure(input string what, input rsp_word_type got,
                                        input rsp_word_type want);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("[%0t] %s", $time, what);
         $display("   expected %s", word_text(want));
         $display("   actual   %s", word_text(got));
      end
   endfunction

   // -------------------------------------------------------------------------
   // Request side. Hold each word until ready; on acceptance, run the table
   // copy and queue what the block now owes.
   // -------------------------------------------------------------------------
   task automatic send_word(input logic act,
                            input logic signed [COORD_W-1:0] cx,
                            input logic signed [COORD_W-1:0] cz,
                            input logic typed,
                            input rsp_word_type typed_word);
      int unsigned gap;
      gap = brisk ? 0 : $urandom_range(0, MAX_IDLE);
      // Drop valid only across a gap, so back-to-back words keep it high.
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.coord_x <= cx;
      req_ch.coord_z <= cz;
      do @(posedge clock); while (!req_ch.ready);
      window_step(act, cx, cz);
      if (typed) begin
         pending_words.push_back(typed_word);
      end else begin
         foreach (step_words[i]) pending_words.push_back(step_words[i]);
      end
      if (act == ACT_LOOKUP) lookups_sent++;
      else recenters_sent++;
   endtask

   initial begin : req_source
      tile_row_type              rows [NUM_ROWS];
      logic                      act;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cz;
      int unsigned               pick;
      int                        reach;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.action  <= ACT_RECENTER;
      req_ch.coord_x <= '0;
      req_ch.coord_z <= '0;
      for (int i = 0; i < WIN_SLOTS; i++) begin
         tile_home_x[i] = '0;
         tile_home_z[i] = '0;
         tile_gen[i]    = '0;
         tile_held[i]   = 1'b0;
      end
      win_x   = '0;
      win_z   = '0;
      win_set = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: lookups before the window is homed, the first full
      // homing, a same-centre recenter, range edges, single steps, a jump, and
      // windows clipped at both ends of the coordinate range.
      rows = '{
         '{ACT_LOOKUP,   0, 0, 1'b1, answer_word('0, 1'b0, '0, 1'b0, '0)},
         '{ACT_LOOKUP,   COORD_MAX, COORD_MIN, 1'b1, answer_word('0, 1'b0, '0, 1'b0, '0)},
         '{ACT_RECENTER, 0, 0, 1'b1, done_word(CHG_W'(WIN_SLOTS))},
         '{ACT_RECENTER, 0, 0, 1'b1, done_word('0)},
         '{ACT_LOOKUP,   0, 0, 1'b1, answer_word('0, 1'b1, '0, 1'b1, GEN_W'(1))},
         '{ACT_LOOKUP,   -3, 3, 1'b0, '0},
         '{ACT_LOOKUP,   4, 0, 1'b1, answer_word('0, 1'b0, '0, 1'b0, '0)},
         '{ACT_LOOKUP,   0, -4, 1'b1, answer_word('0, 1'b0, '0, 1'b0, '0)},
         '{ACT_RECENTER, 1, 0, 1'b0, '0},
         '{ACT_RECENTER, 2, 1, 1'b0, '0},
         '{ACT_LOOKUP,   -1, -2, 1'b0, '0},
         '{ACT_RECENTER, -5, 9, 1'b0, '0},
         '{ACT_RECENTER, COORD_MAX, COORD_MAX, 1'b0, '0},
         '{ACT_LOOKUP,   COORD_MAX, COORD_MAX, 1'b0, '0},
         '{ACT_LOOKUP,   COORD_MAX - 3, COORD_MAX - 2, 1'b0, '0},
         '{ACT_RECENTER, COORD_MAX - 1, COORD_MAX, 1'b0, '0},
         '{ACT_RECENTER, COORD_MIN, COORD_MIN, 1'b0, '0},
         '{ACT_LOOKUP,   COORD_MIN, COORD_MIN, 1'b0, '0},
         '{ACT_LOOKUP,   COORD_MIN + 3, COORD_MIN + 2, 1'b0, '0},
         '{ACT_RECENTER, COORD_MIN, COORD_MAX, 1'b0, '0},
         '{ACT_LOOKUP,   COORD_MIN + 2, COORD_MAX - 3, 1'b0, '0},
         '{ACT_RECENTER, COORD_MAX, COORD_MIN, 1'b0, '0},
         '{ACT_RECENTER, COORD_MAX, COORD_MIN, 1'b1, done_word('0)},
         // Far across the range: the gap is exact, not wrapped, so this misses.
         '{ACT_LOOKUP,   COORD_MIN, COORD_MIN, 1'b1, answer_word('0, 1'b0, '0, 1'b0, '0)},
         '{ACT_RECENTER, 0, 0, 1'b0, '0}
      };
      foreach (rows[i]) send_word(rows[i].action, rows[i].x, rows[i].z, rows[i].typed,
                                  rows[i].word);

      // Random part: mostly lookups and recenters close to the centre so the
      // table keeps real content, plus far jumps, full-range noise and edges.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         brisk = (n >= BRISK_FIRST && n <= BRISK_LAST);
         if (n == HOLD_AT) hold_rsp = 1'b1;
         if (n == SETTLE_AT) begin
            // Pause until the block has delivered everything it owes.
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_words.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         act  = (pick < 55) ? ACT_LOOKUP : ACT_RECENTER;
         if (pick < 40 || (pick >= 55 && pick < 90)) begin
            reach = (pick < 40) ? WIN_RADIUS + 1 : ((pick < 80) ? 1 : 5);
            cx = COORD_W'(longint'(win_x) + longint'($urandom_range(0, 2 * reach)) - reach);
            cz = COORD_W'(longint'(win_z) + longint'($urandom_range(0, 2 * reach)) - reach);
         end else if (pick < 97) begin
            cx = COORD_W'($urandom());
            cz = COORD_W'($urandom());
         end else begin
            cx = COORD_W'($urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 4)
                                               : COORD_MIN + $urandom_range(0, 4));
            cz = COORD_W'($urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 4)
                                               : COORD_MIN + $urandom_range(0, 4));
         end
         send_word(act, cx, cz, 1'b0, '0);
      end
      brisk = 1'b0;

      // Drain: wait out every owed word, then a quiet stretch for strays.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0d expected words never arrived", pending_words.size());
         failures += pending_words.size();
      end

      $display("Sent %0d recenters and %0d lookups across both coordinate extremes;",
               recenters_sent, lookups_sent);
      $display("checked %0d response words including %0d evictions, %0d failures.",
               words_checked, evictions_seen, failures);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side. Stall a random number of cycles before each word, hold
   // off once for a long stretch, and compare each word with the oldest one
   // owed.
   // -------------------------------------------------------------------------
   initial begin : rsp_sink
      rsp_word_type got;
      rsp_word_type want;
      int unsigned  stall;

      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = brisk ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);

         got.kind       = rsp_ch.kind;
         got.last       = rsp_ch.last;
         got.old_x      = rsp_ch.old_x;
         got.old_z      = rsp_ch.old_z;
         got.slot       = rsp_ch.slot;
         got.in_range   = rsp_ch.in_range;
         got.distance   = rsp_ch.distance;
         got.hit        = rsp_ch.hit;
         got.generation = rsp_ch.generation;
         got.changed    = rsp_ch.changed;

         if (pending_words.size() == 0) begin
            note_failure("response word with nothing expected", got, '0);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (got !== want) note_failure("response word mismatch", got, want);
            else if (want.kind == KIND_EVICT) evictions_seen++;
         end
      end
   end

   // Advance the cycle count; end the run if it never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
                  pending_words.size());
         $display("Verification failed");
         $finish;
      end
   end

endmodule
